// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

  // Default table depths
  localparam int MAX_PATTERN_DEF     = 32;
  localparam int MAX_REPLACEMENT_DEF = 32;

  // Register file layout
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int LEN_W       = 6;
  localparam int COUNT_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT       = 2'd2;

  localparam logic [LEN_W-1:0]   PATTERN_LENGTH_RST     = 6'd1;
  localparam logic [LEN_W-1:0]   REPLACEMENT_LENGTH_RST = 6'd0;
  localparam logic [COUNT_W-1:0] OUTPUT_LIMIT_RST       = 12'd1023;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOAD_PATTERN = 2'd0,
    REQ_LOAD_REPLACE = 2'd1,
    REQ_NAME_BYTE    = 2'd2,
    REQ_END_OF_NAME  = 2'd3
  } sfr_req_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] table_index;
    logic [7:0] data_byte;
  } sfr_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       aborted;
  } sfr_resp_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic win_we;
    logic pat_we;
    logic active;
  } sfr_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_REPL,
    S_DROP,
    S_FLUSH
  } sfr_state_t;

endpackage

// ===== hw/rtl/sfr_cell.sv =====
module sfr_cell (
  input  logic                   clk,
  input  sfr_pkg::sfr_cell_ctrl_t ctrl,
  input  logic [7:0]             new_byte,
  input  logic [7:0]             next_byte,
  output logic [7:0]             win_byte,
  output logic                   eq
);
  import sfr_pkg::*;

  logic [7:0] pat_byte;

  // Hold one window byte and one pattern byte; shift toward the front
  always_ff @(posedge clk) begin
    if (ctrl.win_we) begin
      win_byte <= new_byte;
    end else if (ctrl.shift) begin
      win_byte <= next_byte;
    end
    if (ctrl.pat_we) begin
      pat_byte <= new_byte;
    end
  end

  // Cells past the pattern length always agree
  assign eq = !ctrl.active || (win_byte == pat_byte);

endmodule

// ===== hw/rtl/stream_find_and_replace.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    sfr_req_t  (type, index, byte)
// resp      out        resp_valid / resp_ready  sfr_resp_t (byte, valid, last, aborted)
// cfg       in         cfg_we                   cfg_index, cfg_data
//
// A name byte enters the window row; once the window holds a full pattern the sequencer
// decides: a match emits the replacement bytes and then shifts the matched bytes out of
// the row, a miss emits the oldest byte, and output over the limit aborts the name.
// End of name emits the leftover window bytes as far as the limit allows, then the
// final item.
// Reset (rst, synchronous) clears the sequencer, counters and registers; tables hold.
// A stalled resp holds the sequencer in any state that emits.
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  sfr_pkg::sfr_req_t                req,
  output logic                             resp_valid,
  input  logic                             resp_ready,
  output sfr_pkg::sfr_resp_t               resp,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfr_pkg::*;

  localparam int PW  = $clog2(MAX_PATTERN + 1);
  localparam int RLW = $clog2(MAX_REPLACEMENT + 1);
  localparam int RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  sfr_state_t state, state_next;

  logic [LEN_W-1:0]   plen_r, rlen_r;
  logic [COUNT_W-1:0] limit_r;

  logic [PW-1:0]      fill, fill_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               discarding, discarding_next;
  logic [RLW-1:0]     rep_idx, rep_idx_next;
  logic [PW-1:0]      drop_cnt, drop_cnt_next;

  logic [7:0] rep_tab [MAX_REPLACEMENT];

  logic [PW-1:0]  plen_eff;
  logic [RLW-1:0] rlen_eff;

  logic           shift, ins_we, load_pat, load_rep;
  logic           emit;
  sfr_resp_t      item;
  logic           out_free;
  logic           match;
  logic [12:0]    addlen;
  logic           over;

  sfr_cell_ctrl_t ctrl [MAX_PATTERN];
  logic [7:0]     win  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;

  // Clamp the lengths to what the row and table hold; a zero pattern length counts as one
  always_comb begin
    if (plen_r == '0) begin
      plen_eff = PW'(1);
    end else if (32'(plen_r) > MAX_PATTERN) begin
      plen_eff = PW'(MAX_PATTERN);
    end else begin
      plen_eff = PW'(plen_r);
    end
    if (32'(rlen_r) > MAX_REPLACEMENT) begin
      rlen_eff = RLW'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = RLW'(rlen_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plen_r  <= PATTERN_LENGTH_RST;
      rlen_r  <= REPLACEMENT_LENGTH_RST;
      limit_r <= OUTPUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH:     plen_r  <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_LENGTH: rlen_r  <= cfg_data[LEN_W-1:0];
        CFG_OUTPUT_LIMIT:       limit_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Row of window cells
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic [7:0] nb;
      if (gi == MAX_PATTERN - 1) begin : g_tail
        assign nb = 8'h00;
      end else begin : g_link
        assign nb = win[gi+1];
      end
      assign ctrl[gi].shift  = shift;
      assign ctrl[gi].win_we = ins_we && (32'(fill) == gi);
      assign ctrl[gi].pat_we = load_pat && (32'(req.table_index) == gi);
      assign ctrl[gi].active = gi < 32'(plen_eff);
      sfr_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[gi]),
        .new_byte  (req.data_byte),
        .next_byte (nb),
        .win_byte  (win[gi]),
        .eq        (eq[gi])
      );
    end
  endgenerate

  assign match    = &eq;
  assign addlen   = match ? 13'(rlen_eff) : 13'd1;
  assign over     = (13'(count) + addlen) > 13'(limit_r);
  assign out_free = !resp_valid || resp_ready;
  assign req_ready = (state == S_IDLE);

  // Replacement table
  always_ff @(posedge clk) begin
    if (load_rep) begin
      rep_tab[RIW'(req.table_index)] <= req.data_byte;
    end
  end

  // Sequencer: next state and per-cycle actions
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    count_next      = count;
    discarding_next = discarding;
    rep_idx_next    = rep_idx;
    drop_cnt_next   = drop_cnt;
    shift           = 1'b0;
    ins_we          = 1'b0;
    load_pat        = 1'b0;
    load_rep        = 1'b0;
    emit            = 1'b0;
    item            = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.req_type)
            REQ_LOAD_PATTERN: load_pat = 1'b1;
            REQ_LOAD_REPLACE: load_rep = 32'(req.table_index) < MAX_REPLACEMENT;
            REQ_NAME_BYTE: begin
              if (!discarding) begin
                if (32'(fill) < MAX_PATTERN) begin
                  ins_we    = 1'b1;
                  fill_next = fill + PW'(1);
                end
                if (fill_next >= plen_eff) begin
                  state_next = S_DECIDE;
                end
              end
            end
            default: state_next = S_FLUSH;
          endcase
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          if (over) begin
            emit            = 1'b1;
            item.aborted    = 1'b1;
            discarding_next = 1'b1;
            fill_next       = '0;
            state_next      = S_IDLE;
          end else if (match) begin
            count_next    = count + COUNT_W'(addlen);
            rep_idx_next  = '0;
            drop_cnt_next = plen_eff;
            state_next    = (rlen_eff != '0) ? S_REPL : S_DROP;
          end else begin
            emit            = 1'b1;
            item.out_byte   = win[0];
            item.byte_valid = 1'b1;
            shift           = 1'b1;
            fill_next       = fill - PW'(1);
            count_next      = count + COUNT_W'(1);
            state_next      = S_IDLE;
          end
        end
      end
      S_REPL: begin
        // The table byte itself is picked up by the output register
        if (out_free) begin
          emit            = 1'b1;
          item.byte_valid = 1'b1;
          rep_idx_next    = rep_idx + RLW'(1);
          if (rep_idx_next == rlen_eff) begin
            state_next = S_DROP;
          end
        end
      end
      S_DROP: begin
        // Drop the matched bytes from the front, one per cycle
        shift         = 1'b1;
        fill_next     = fill - PW'(1);
        drop_cnt_next = drop_cnt - PW'(1);
        if (drop_cnt == PW'(1) || fill == PW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (fill != '0 && (13'(count) + 13'd1) <= 13'(limit_r)) begin
            item.out_byte   = win[0];
            item.byte_valid = 1'b1;
            shift           = 1'b1;
            fill_next       = fill - PW'(1);
            count_next      = count + COUNT_W'(1);
          end else begin
            item.last       = 1'b1;
            item.aborted    = discarding || (fill != '0);
            fill_next       = '0;
            count_next      = '0;
            discarding_next = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer state and name counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      count      <= '0;
      discarding <= 1'b0;
      rep_idx    <= '0;
      drop_cnt   <= '0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      count      <= count_next;
      discarding <= discarding_next;
      rep_idx    <= rep_idx_next;
      drop_cnt   <= drop_cnt_next;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (emit) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  // Load the result; replacement bytes come straight from the table
  always_ff @(posedge clk) begin
    if (emit) begin
      resp.out_byte   <= (state == S_REPL) ? rep_tab[rep_idx[RIW-1:0]] : item.out_byte;
      resp.byte_valid <= item.byte_valid;
      resp.last       <= item.last;
      resp.aborted    <= item.aborted;
    end
  end

endmodule

// ===== dv/tb_stream_find_and_replace.sv =====
module tb_stream_find_and_replace;
  import sfr_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int NUM_ITEMS    = 410;

  // Rewrite predictor plus the queue of bytes and markers still owed by the block
  class name_rewrite_board;
    logic [7:0]         pat_tab [MAX_PATTERN_DEF];
    logic [7:0]         rep_tab [MAX_REPLACEMENT_DEF];
    logic [7:0]         window  [MAX_PATTERN_DEF];
    int unsigned        fill;
    int unsigned        out_count;
    bit                 discarding;
    logic [LEN_W-1:0]   plen_reg;
    logic [LEN_W-1:0]   rlen_reg;
    logic [COUNT_W-1:0] limit_reg;
    sfr_resp_t          rewritten_q[$];
    int                 errors;

    function new();
      foreach (pat_tab[i]) pat_tab[i] = '0;
      foreach (rep_tab[i]) rep_tab[i] = '0;
      foreach (window[i]) window[i] = '0;
      fill       = 0;
      out_count  = 0;
      discarding = 1'b0;
      plen_reg   = PATTERN_LENGTH_RST;
      rlen_reg   = REPLACEMENT_LENGTH_RST;
      limit_reg  = OUTPUT_LIMIT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_PATTERN_LENGTH:     plen_reg  = data[LEN_W-1:0];
        CFG_REPLACEMENT_LENGTH: rlen_reg  = data[LEN_W-1:0];
        CFG_OUTPUT_LIMIT:       limit_reg = data;
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b, bit valid, bit last, bit aborted);
      sfr_resp_t r;
      r.out_byte   = valid ? b : 8'h00;
      r.byte_valid = valid;
      r.last       = last;
      r.aborted    = aborted;
      rewritten_q.push_back(r);
    endfunction

    // Shift the window left by k bytes
    function void drop_oldest(int unsigned k);
      if (k >= fill) begin
        fill = 0;
        return;
      end
      for (int i = 0; i < fill - k; i++) window[i] = window[i + k];
      fill -= k;
    endfunction

    function void advance_window(logic [7:0] b);
      int unsigned pl;
      int unsigned rl;
      int unsigned addlen;
      bit          hit;
      pl = (plen_reg == 0) ? 1 :
           ((plen_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen_reg);
      rl = (rlen_reg > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rlen_reg;
      if (discarding) return;
      if (fill < MAX_PATTERN_DEF) begin
        window[fill] = b;
        fill++;
      end
      if (fill < pl) return;
      // one decision per name byte: whole replacement, the oldest byte or an abort
      hit = 1'b1;
      for (int i = 0; i < pl; i++) if (window[i] != pat_tab[i]) hit = 1'b0;
      addlen = hit ? rl : 1;
      if (out_count + addlen > limit_reg) begin
        emit(8'h00, 1'b0, 1'b0, 1'b1);
        discarding = 1'b1;
        fill = 0;
        return;
      end
      if (hit) begin
        for (int i = 0; i < addlen; i++) emit(rep_tab[i], 1'b1, 1'b0, 1'b0);
        drop_oldest(pl);
      end else begin
        emit(window[0], 1'b1, 1'b0, 1'b0);
        drop_oldest(1);
      end
      out_count += addlen;
    endfunction

    // Flush the leftover window as is, then close the name
    function void finish_name();
      bit refused;
      refused = discarding;
      if (!refused) begin
        for (int i = 0; i < fill; i++) begin
          if (out_count + 1 > limit_reg) begin
            refused = 1'b1;
            break;
          end
          emit(window[i], 1'b1, 1'b0, 1'b0);
          out_count++;
        end
      end
      emit(8'h00, 1'b0, 1'b1, refused);
      fill       = 0;
      out_count  = 0;
      discarding = 1'b0;
    endfunction

    function void take_request(sfr_req_t r);
      case (sfr_req_kind_t'(r.req_type))
        REQ_LOAD_PATTERN: pat_tab[r.table_index] = r.data_byte;
        REQ_LOAD_REPLACE: rep_tab[r.table_index] = r.data_byte;
        REQ_NAME_BYTE:    advance_window(r.data_byte);
        REQ_END_OF_NAME:  finish_name();
        default: ;
      endcase
    endfunction

    function void compare_field(string fld, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", fld, want, got);
        errors++;
      end
    endfunction

    function void check_response(sfr_resp_t got);
      sfr_resp_t want;
      if (rewritten_q.size() == 0) begin
        $error("unexpected response: out_byte 0x%0h byte_valid %0b last %0b aborted %0b",
               got.out_byte, got.byte_valid, got.last, got.aborted);
        errors++;
        return;
      end
      want = rewritten_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare_field("last", 8'(want.last), 8'(got.last));
      compare_field("aborted", 8'(want.aborted), 8'(got.aborted));
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   req_valid  = 1'b0;
  logic                   req_ready;
  sfr_req_t               req        = '0;
  logic                   resp_valid;
  logic                   resp_ready = 1'b0;
  sfr_resp_t              resp;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  name_rewrite_board board = new();

  bit          calm       = 1'b0;
  int          items_sent = 0;
  int unsigned cur_plen   = 1;
  int unsigned cur_rlen   = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  pat_shadow [MAX_PATTERN_DEF];
  bit          pat_loaded [MAX_PATTERN_DEF];
  bit          rep_loaded [MAX_REPLACEMENT_DEF];

  stream_find_and_replace dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the response side at random, except in the calm phase
  always @(posedge clk) begin
    resp_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Predict on every accepted request, check every accepted response
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.take_request(req);
      if (resp_valid && resp_ready) board.check_response(resp);
    end
  end

  // Abort the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (resp_valid && resp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic put_req(sfr_req_kind_t kind, logic [4:0] idx, logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < 25) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{req_type: kind, table_index: idx, data_byte: data};
    if (kind == REQ_LOAD_PATTERN) begin
      pat_shadow[idx] = data;
      pat_loaded[idx] = 1'b1;
    end
    if (kind == REQ_LOAD_REPLACE) rep_loaded[idx] = 1'b1;
    items_sent++;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Hold requests until every owed response is back and the block has settled
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (board.rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic drive_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    board.write_reg(index, data);
    @(posedge clk);
  endtask

  task automatic write_regs(logic [LEN_W-1:0] pl, logic [LEN_W-1:0] rl,
                            logic [COUNT_W-1:0] lim);
    drive_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(pl));
    drive_reg(CFG_REPLACEMENT_LENGTH, CFG_DATA_W'(rl));
    drive_reg(CFG_OUTPUT_LIMIT, lim);
    cfg_we   <= 1'b0;
    cur_plen = (pl == 0) ? 1 : ((pl > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pl);
    cur_rlen = (rl > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rl;
  endtask

  // Load every table entry the current lengths can read and that is not loaded yet
  task automatic fill_tables();
    for (int i = 0; i < cur_plen; i++)
      if (!pat_loaded[i]) put_req(REQ_LOAD_PATTERN, 5'(i), 8'($urandom_range(0, 255)));
    for (int i = 0; i < cur_rlen; i++)
      if (!rep_loaded[i]) put_req(REQ_LOAD_REPLACE, 5'(i), 8'($urandom_range(0, 255)));
  endtask

  // Stream len name bytes rich in pattern copies and near misses
  task automatic send_name(int unsigned len, bit close);
    int unsigned k;
    int unsigned run;
    int unsigned pick;
    k = 0;
    while (k < len) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // full pattern, or a broken prefix of it
        run = (pick == 3) ? $urandom_range(1, cur_plen) : cur_plen;
        for (int j = 0; j < run && k < len; j++) begin
          put_req(REQ_NAME_BYTE, 5'($urandom_range(0, 31)), pat_shadow[j]);
          k++;
        end
      end else if (pick == 4) begin
        // reload a table entry mid-name
        put_req(sfr_req_kind_t'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)));
      end else if (pick <= 7) begin
        put_req(REQ_NAME_BYTE, 5'($urandom_range(0, 31)),
                pat_shadow[$urandom_range(0, cur_plen - 1)]);
        k++;
      end else begin
        put_req(REQ_NAME_BYTE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        k++;
      end
    end
    if (close) put_req(REQ_END_OF_NAME, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit                 name_open;
    int unsigned        phase;
    int unsigned        names;
    logic [LEN_W-1:0]   pl;
    logic [LEN_W-1:0]   rl;
    logic [COUNT_W-1:0] lim;

    foreach (pat_loaded[i]) pat_loaded[i] = 1'b0;
    foreach (rep_loaded[i]) rep_loaded[i] = 1'b0;
    foreach (pat_shadow[i]) pat_shadow[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one-byte pattern with an empty replacement deletes it
    put_req(REQ_LOAD_PATTERN, 5'd0, 8'h00);
    put_req(REQ_LOAD_REPLACE, 5'd31, 8'hFF);
    put_req(REQ_NAME_BYTE, 5'd31, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'hFF);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_END_OF_NAME, 5'd0, 8'h00);
    // empty name
    put_req(REQ_END_OF_NAME, 5'd31, 8'hFF);
    drain();

    // Two matches and a leftover byte flushed at end of name
    write_regs(6'd2, 6'd3, 12'd1023);
    put_req(REQ_LOAD_PATTERN, 5'd1, 8'h41);
    put_req(REQ_LOAD_REPLACE, 5'd0, 8'h5A);
    put_req(REQ_LOAD_REPLACE, 5'd1, 8'h00);
    put_req(REQ_LOAD_REPLACE, 5'd2, 8'hFF);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h41);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h41);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h41);
    put_req(REQ_END_OF_NAME, 5'd0, 8'h00);
    drain();

    // Tight limit: refused on a match, discard the rest, then refused in the flush
    write_regs(6'd2, 6'd3, 12'd2);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h41);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h7E);
    put_req(REQ_END_OF_NAME, 5'd0, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h7E);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h7E);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h7E);
    put_req(REQ_END_OF_NAME, 5'd0, 8'h00);
    drain();

    // Lower the pattern length while a name is half way in
    write_regs(6'd3, 6'd1, 12'd1023);
    fill_tables();
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h41);
    drain();
    write_regs(6'd1, 6'd1, 12'd1023);
    put_req(REQ_NAME_BYTE, 5'd0, 8'h00);
    put_req(REQ_END_OF_NAME, 5'd0, 8'h00);

    // Random phases; a name may stay open across a settings change
    name_open = 1'b0;
    phase = 0;
    while (items_sent < NUM_ITEMS) begin
      case (phase)
        0: begin pl = 6'd63; rl = 6'd63; lim = 12'd4095; end
        1: begin pl = 6'd0;  rl = 6'd32; lim = 12'd1;    end
        2: begin pl = 6'd32; rl = 6'd0;  lim = 12'd0;    end
        default: begin
          case ($urandom_range(0, 9))
            0:       pl = 6'd0;
            1:       pl = 6'd63;
            2:       pl = 6'd32;
            default: pl = 6'($urandom_range(1, 6));
          endcase
          case ($urandom_range(0, 7))
            0:       rl = 6'd0;
            1:       rl = 6'd63;
            2:       rl = 6'd32;
            default: rl = 6'($urandom_range(0, 5));
          endcase
          case ($urandom_range(0, 7))
            0:       lim = 12'd1;
            1:       lim = 12'd4095;
            2:       lim = 12'd0;
            3, 4:    lim = 12'($urandom_range(2, 24));
            default: lim = 12'($urandom_range(25, 1023));
          endcase
        end
      endcase
      drain();
      calm = (phase == 0);
      write_regs(pl, rl, lim);
      fill_tables();
      names = $urandom_range(2, 5);
      for (int n = 0; n < names; n++) begin
        name_open = (n == names - 1) && ($urandom_range(0, 3) == 0);
        send_name($urandom_range(0, cur_plen + 10), !name_open);
      end
      phase++;
    end
    calm = 1'b0;
    if (name_open) put_req(REQ_END_OF_NAME, 5'd0, 8'h00);
    drain();

    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
